FILE: hdl/clnw_pkg.sv
// shared types, codes and phase table for the character lcd nibble writer
// no dependencies; imported by every module of the block
`default_nettype none

package clnw_pkg;

  // request command codes
  localparam logic [1:0] CMD_INSTR  = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_CURSOR = 2'd2;
  localparam logic [1:0] CMD_BUSY   = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PULSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_GAP   = 1'b1;
  localparam int unsigned CFG_DATA_W = 16;

  // reset values of the configuration registers
  localparam logic [7:0]  PULSE_RESET = 8'd1;
  localparam logic [15:0] GAP_RESET   = 16'd1000;

  // ddram row base addresses
  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;
  localparam logic [7:0] ROW2_BASE = 8'h94;
  localparam logic [7:0] ROW3_BASE = 8'hD4;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // default depth of the job queue
  localparam int unsigned JOB_QUEUE_DEPTH = 4;

  // phase index, wide enough for the longest job (six phases)
  localparam int unsigned PHASE_IDX_W = 3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
    logic [2:0] row;
    logic [6:0] column;
    logic       busy_flag;
  } in_item_t;

  typedef struct packed {
    logic        reg_select;
    logic        read_not_write;
    logic        enable_level;
    logic [3:0]  bus_nibble;
    logic        d7_is_input;
    logic [15:0] hold_us;
    logic        sample_busy;
    logic        last_phase;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_POLL_BUSY,
    JOB_POLL_DONE
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] value;
  } job_t;

  // ddram set-address instruction for a cursor row, eight-bit wrap
  function automatic logic [7:0] cursor_addr(input logic [1:0] row,
                                             input logic [6:0] column);
    logic [7:0] base;
    case (row)
      2'd0:    base = ROW0_BASE;
      2'd1:    base = ROW1_BASE;
      2'd2:    base = ROW2_BASE;
      default: base = ROW3_BASE;
    endcase
    return base + {1'b0, column};
  endfunction

  // index of the final phase of a job
  function automatic logic [PHASE_IDX_W-1:0] last_idx(input job_kind_t kind);
    logic [PHASE_IDX_W-1:0] n;
    unique case (kind)
      JOB_WRITE:     n = PHASE_IDX_W'(5);
      JOB_POLL_BUSY: n = PHASE_IDX_W'(3);
      JOB_POLL_DONE: n = PHASE_IDX_W'(2);
      default:       n = PHASE_IDX_W'(0);
    endcase
    return n;
  endfunction

  // pin settings of one phase of a job
  function automatic out_item_t make_phase(input job_t job,
                                           input logic [PHASE_IDX_W-1:0] idx,
                                           input logic [7:0] pulse,
                                           input logic [15:0] gap);
    out_item_t  p;
    logic [15:0] pulse_w;
    logic [3:0]  hi;
    logic [3:0]  lo;
    pulse_w = {8'd0, pulse};
    hi      = job.value[7:4] & NIBBLE_MASK;
    lo      = job.value[3:0] & NIBBLE_MASK;
    p       = '0;
    p.last_phase = (idx == last_idx(job.kind));
    if (job.kind == JOB_WRITE) begin
      case (idx)
        PHASE_IDX_W'(0): begin
          p.reg_select = job.rs; p.enable_level = 1'b1;
          p.bus_nibble = hi;     p.hold_us = pulse_w;
        end
        PHASE_IDX_W'(1): begin
          p.reg_select = job.rs; p.bus_nibble = hi; p.hold_us = gap;
        end
        PHASE_IDX_W'(2): begin
          p.reg_select = job.rs; p.enable_level = 1'b1;
          p.bus_nibble = lo;     p.hold_us = pulse_w;
        end
        PHASE_IDX_W'(3): begin
          p.reg_select = job.rs; p.bus_nibble = lo;
        end
        PHASE_IDX_W'(4): begin
          p.read_not_write = 1'b1; p.d7_is_input = 1'b1; p.hold_us = pulse_w;
        end
        default: begin
          p.read_not_write = 1'b1; p.d7_is_input = 1'b1;
          p.enable_level   = 1'b1; p.sample_busy = 1'b1;
        end
      endcase
    end else begin
      case (idx)
        PHASE_IDX_W'(0), PHASE_IDX_W'(2): begin
          if (idx == PHASE_IDX_W'(0) || job.kind == JOB_POLL_BUSY) begin
            p.read_not_write = 1'b1; p.d7_is_input = 1'b1;
            p.hold_us = pulse_w;
          end
        end
        default: begin
          // enable high on the read phases; sample only at the end of a busy poll
          p.read_not_write = 1'b1; p.d7_is_input = 1'b1;
          p.enable_level   = 1'b1;
          p.sample_busy    = (idx == PHASE_IDX_W'(3));
        end
      endcase
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/clnw_front.sv
// front end: accepts requests, tracks busy polling, turns requests into jobs
// depends on clnw_pkg
`default_nettype none

module clnw_front import clnw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_data,
  output logic          in_full,
  output logic          q_push,
  output job_t          q_data,
  input  wire logic     q_full
);

  logic polling_r;
  logic polling_nxt;
  logic accept;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  // classify the request
  always_comb begin
    q_push      = 1'b0;
    q_data      = '{kind: JOB_WRITE, rs: 1'b0, value: in_data.byte_value};
    polling_nxt = polling_r;
    if (accept) begin
      if (in_data.command == CMD_BUSY) begin
        if (polling_r) begin
          q_push = 1'b1;
          if (in_data.busy_flag) begin
            q_data.kind = JOB_POLL_BUSY;
          end else begin
            q_data.kind = JOB_POLL_DONE;
            polling_nxt = 1'b0;
          end
        end
      end else if (!polling_r) begin
        case (in_data.command)
          CMD_INSTR: begin
            q_push = 1'b1;
          end
          CMD_DATA: begin
            q_push    = 1'b1;
            q_data.rs = 1'b1;
          end
          default: begin
            q_push       = (in_data.row[2] == 1'b0);
            q_data.value = cursor_addr(in_data.row[1:0], in_data.column);
          end
        endcase
        if (q_push) begin
          polling_nxt = 1'b1;
        end
      end
    end
  end

  // polling state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polling_r <= 1'b0;
    end else begin
      polling_r <= polling_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/clnw_fifo.sv
// small job queue between the front end and the phase sequencer
// depends on clnw_pkg
`default_nettype none

module clnw_fifo import clnw_pkg::*; #(
  parameter int unsigned DEPTH = JOB_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // fill count never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("job queue count out of range");

endmodule

`default_nettype wire

FILE: hdl/clnw_back.sv
// back end: steps through the phases of each job, one phase per cycle while out_pop takes them
// depends on clnw_pkg
`default_nettype none

module clnw_back import clnw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  pulse,
  input  wire logic [15:0] gap,
  input  wire job_t        q_data,
  input  wire logic        q_empty,
  output logic             q_pop,
  output out_item_t        out_data,
  output logic             out_empty,
  input  wire logic        out_pop
);

  job_t                   job_r;
  job_t                   job_nxt;
  logic                   job_valid_r;
  logic                   job_valid_nxt;
  logic [PHASE_IDX_W-1:0] idx_r;
  logic [PHASE_IDX_W-1:0] idx_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  out_item_t              out_data_r;
  out_item_t              out_data_nxt;
  logic                   advance;
  logic                   produce;
  logic                   at_last;

  assign advance   = !out_valid_r || out_pop;
  assign produce   = advance && job_valid_r;
  assign at_last   = (idx_r == last_idx(job_r.kind));
  assign q_pop     = !q_empty && (!job_valid_r || (produce && at_last));
  assign out_data  = out_data_r;
  assign out_empty = !out_valid_r;

  // sequencer and output register next values
  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_data_nxt  = out_data_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = make_phase(job_r, idx_r, pulse, gap);
      idx_nxt       = idx_r + 1'b1;
      if (at_last) begin
        job_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      job_nxt       = q_data;
      job_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    out_data_r <= out_data_nxt;
  end

  // phase index stays within the current job
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> idx_r <= last_idx(job_r.kind))
    else $error("phase index past end of job");

  // a job is only taken from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job queue popped while empty");

  // a produced phase shows on the output in the next cycle
  a_produce_shows: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> out_valid_r)
    else $error("produced phase lost");

endmodule

`default_nettype wire

FILE: hdl/char_lcd_nibble_writer.sv
// top level of the character lcd 4-bit nibble writer
// depends on clnw_pkg, clnw_front, clnw_fifo, clnw_back
//
//   channel   ports                         direction  moves
//   in        in_push in_full in_data       in         one request
//   out       out_pop out_empty out_data    out        one pin phase
//   cfg       cfg_we cfg_index cfg_wdata    in         one register write
//
// one pin phase per cycle while out_pop takes them: a write is 6 phases,
// a busy sample 3 or 4, set by the phase sequencer in the back end.
// a request is accepted every cycle the job queue has room; ignored
// requests are taken but give no phases.
// the job queue lets requests keep arriving while phases wait on out_pop.
// synchronous active-low reset clears polling state, queue, output and cfg.
`default_nettype none

module char_lcd_nibble_writer import clnw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire in_item_t              in_data,
  output logic                       in_full,
  output out_item_t                  out_data,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0]  pulse_r;
  logic [15:0] gap_r;
  logic        q_push;
  job_t        q_wdata;
  logic        q_full;
  logic        q_pop;
  job_t        q_rdata;
  logic        q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r <= PULSE_RESET;
      gap_r   <= GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE_PULSE: pulse_r <= cfg_wdata[7:0];
        CFG_NIBBLE_GAP:   gap_r   <= cfg_wdata[15:0];
        default:          ;
      endcase
    end
  end

  clnw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  clnw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  clnw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pulse     (pulse_r),
    .gap       (gap_r),
    .q_data    (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

`default_nettype wire

FILE: sim/char_lcd_nibble_writer_test.sv
// testbench for char_lcd_nibble_writer: pin phases of lcd writes and busy polls
// depends on clnw_pkg and the char_lcd_nibble_writer rtl; self-checking
`timescale 1ns / 1ps

import clnw_pkg::*;

// expected pin phases for every accepted request, checked in order
class lcd_phase_board;
  logic [7:0]  pulse_us;
  logic [15:0] gap_us;
  bit          polling;
  int          errors;
  out_item_t   phase_q[$];

  function new();
    pulse_us       = PULSE_RESET;
    gap_us         = GAP_RESET;
    polling        = 1'b0;
    errors         = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    if (idx == CFG_ENABLE_PULSE) begin
      pulse_us = value[7:0];
    end else begin
      gap_us = value;
    end
  endfunction

  function void add_phase(bit rs, bit rw, bit en, logic [3:0] nib, bit d7in,
                          logic [15:0] hold, bit sample, bit last);
    out_item_t p;
    p.reg_select     = rs;
    p.read_not_write = rw;
    p.enable_level   = en;
    p.bus_nibble     = nib;
    p.d7_is_input    = d7in;
    p.hold_us        = hold;
    p.sample_busy    = sample;
    p.last_phase     = last;
    phase_q.push_back(p);
  endfunction

  // two nibble transfers, then the first busy read
  function void add_byte_write(bit rs, logic [7:0] value);
    logic [15:0] pw;
    pw = {8'd0, pulse_us};
    add_phase(rs, 1'b0, 1'b1, value[7:4], 1'b0, pw, 1'b0, 1'b0);
    add_phase(rs, 1'b0, 1'b0, value[7:4], 1'b0, gap_us, 1'b0, 1'b0);
    add_phase(rs, 1'b0, 1'b1, value[3:0], 1'b0, pw, 1'b0, 1'b0);
    add_phase(rs, 1'b0, 1'b0, value[3:0], 1'b0, 16'd0, 1'b0, 1'b0);
    add_phase(1'b0, 1'b1, 1'b0, 4'd0, 1'b1, pw, 1'b0, 1'b0);
    add_phase(1'b0, 1'b1, 1'b1, 4'd0, 1'b1, 16'd0, 1'b1, 1'b1);
    polling = 1'b1;
  endfunction

  // expand one accepted request into its phases
  function void note_request(in_item_t r);
    logic [15:0] pw;
    logic [7:0]  base;
    pw     = {8'd0, pulse_us};
    if (r.command == CMD_BUSY) begin
      if (polling) begin
        add_phase(1'b0, 1'b1, 1'b0, 4'd0, 1'b1, pw, 1'b0, 1'b0);
        add_phase(1'b0, 1'b1, 1'b1, 4'd0, 1'b1, 16'd0, 1'b0, 1'b0);
        if (r.busy_flag) begin
          add_phase(1'b0, 1'b1, 1'b0, 4'd0, 1'b1, pw, 1'b0, 1'b0);
          add_phase(1'b0, 1'b1, 1'b1, 4'd0, 1'b1, 16'd0, 1'b1, 1'b1);
        end else begin
          // release d7 and give the bus back
          add_phase(1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 16'd0, 1'b0, 1'b1);
          polling = 1'b0;
        end
      end
    end else if (!polling) begin
      case (r.command)
        CMD_INSTR: add_byte_write(1'b0, r.byte_value);
        CMD_DATA:  add_byte_write(1'b1, r.byte_value);
        default: begin
          if (r.row <= 3'd3) begin
            case (r.row[1:0])
              2'd0:    base = ROW0_BASE;
              2'd1:    base = ROW1_BASE;
              2'd2:    base = ROW2_BASE;
              default: base = ROW3_BASE;
            endcase
            add_byte_write(1'b0, base + {1'b0, r.column});
          end
        end
      endcase
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endtask

  task check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // compare one popped phase with the oldest expectation
  task check_phase(out_item_t got);
    out_item_t want;
    if (phase_q.size() == 0) begin
      report($sformatf("phase with nothing pending: %p", got));
      return;
    end
    want = phase_q.pop_front();
    check_field("reg_select", 16'(got.reg_select), 16'(want.reg_select));
    check_field("read_not_write", 16'(got.read_not_write), 16'(want.read_not_write));
    check_field("enable_level", 16'(got.enable_level), 16'(want.enable_level));
    check_field("bus_nibble", 16'(got.bus_nibble), 16'(want.bus_nibble));
    check_field("d7_is_input", 16'(got.d7_is_input), 16'(want.d7_is_input));
    check_field("hold_us", got.hold_us, want.hold_us);
    check_field("sample_busy", 16'(got.sample_busy), 16'(want.sample_busy));
    check_field("last_phase", 16'(got.last_phase), 16'(want.last_phase));
  endtask
endclass

module char_lcd_nibble_writer_test;

  localparam int unsigned STALL_PCT     = 28;
  localparam int unsigned STUCK_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned SEG_REQUESTS  = 91;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  in_item_t              in_data;
  logic                  in_full;
  out_item_t             out_data;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    steady = 1'b0;
  int unsigned           stuck_cycles = 0;
  lcd_phase_board        board;

  char_lcd_nibble_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls except in the steady stretch
  always @(posedge clk) begin
    out_pop <= rst_n && (steady || $urandom_range(99) >= STALL_PCT);
  end

  // result monitor; values read here are the ones before the edge
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) board.check_phase(out_data);
  end

  // watchdog on cycles with no request or phase accepted
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic in_item_t make_request(logic [1:0] cmd, logic [7:0] value,
                                            logic [2:0] row, logic [6:0] col,
                                            logic busy);
    in_item_t r;
    r.command    = cmd;
    r.byte_value = value;
    r.row        = row;
    r.column     = col;
    r.busy_flag  = busy;
    return r;
  endfunction

  // mostly well-formed write/poll sequences, some noise
  function automatic in_item_t next_random_request();
    in_item_t r;
    r.command    = 2'($urandom_range(3));
    r.byte_value = 8'($urandom);
    r.row        = 3'($urandom_range(7));
    r.column     = 7'($urandom);
    r.busy_flag  = 1'($urandom);
    if ($urandom_range(99) < 85) begin
      if (board.polling) begin
        r.command   = CMD_BUSY;
        r.busy_flag = ($urandom_range(99) < 40);
      end else begin
        case ($urandom_range(2))
          0:       r.command = CMD_INSTR;
          1:       r.command = CMD_DATA;
          default: r.command = CMD_CURSOR;
        endcase
        r.row = 3'($urandom_range(3));
      end
    end
    return r;
  endfunction

  task automatic send_request(input in_item_t item);
    if (!steady && $urandom_range(99) < STALL_PCT) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    board.note_request(item);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  // hold off requests until all phases are out, then load both registers
  task automatic reconfigure(input logic [7:0] pulse, input logic [15:0] gap);
    in_push <= 1'b0;
    while (board.phase_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_ENABLE_PULSE, {8'($urandom), pulse});
    write_reg(CFG_NIBBLE_GAP, gap);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_item_t    directed[$];
    int          seg;
    logic [7:0]  pulse;
    logic [15:0] gap;
    board = new();
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored cases, busy retries, every row base and wrap
    directed.push_back(make_request(CMD_INSTR, 8'h00, 3'd0, 7'd0, 1'b0));
    directed.push_back(make_request(CMD_INSTR, 8'h3C, 3'd0, 7'd0, 1'b0));
    directed.push_back(make_request(CMD_BUSY, 8'h00, 3'd0, 7'd0, 1'b1));
    directed.push_back(make_request(CMD_BUSY, 8'hFF, 3'd7, 7'h7F, 1'b0));
    directed.push_back(make_request(CMD_BUSY, 8'h00, 3'd0, 7'd0, 1'b1));
    directed.push_back(make_request(CMD_DATA, 8'hFF, 3'd7, 7'h7F, 1'b1));
    directed.push_back(make_request(CMD_CURSOR, 8'h00, 3'd1, 7'd5, 1'b0));
    directed.push_back(make_request(CMD_DATA, 8'h5A, 3'd0, 7'd0, 1'b0));
    directed.push_back(make_request(CMD_BUSY, 8'h00, 3'd0, 7'd0, 1'b0));
    directed.push_back(make_request(CMD_CURSOR, 8'h00, 3'd0, 7'd0, 1'b0));
    directed.push_back(make_request(CMD_BUSY, 8'h00, 3'd0, 7'd0, 1'b0));
    directed.push_back(make_request(CMD_CURSOR, 8'h00, 3'd1, 7'h7F, 1'b0));
    directed.push_back(make_request(CMD_BUSY, 8'h00, 3'd0, 7'd0, 1'b1));
    directed.push_back(make_request(CMD_BUSY, 8'h00, 3'd0, 7'd0, 1'b0));
    directed.push_back(make_request(CMD_CURSOR, 8'h00, 3'd2, 7'h6B, 1'b0));
    directed.push_back(make_request(CMD_BUSY, 8'h00, 3'd0, 7'd0, 1'b0));
    directed.push_back(make_request(CMD_CURSOR, 8'h00, 3'd3, 7'h7F, 1'b0));
    directed.push_back(make_request(CMD_BUSY, 8'h00, 3'd0, 7'd0, 1'b0));
    directed.push_back(make_request(CMD_CURSOR, 8'h12, 3'd4, 7'd1, 1'b0));
    directed.push_back(make_request(CMD_CURSOR, 8'h34, 3'd5, 7'd2, 1'b0));
    directed.push_back(make_request(CMD_CURSOR, 8'h56, 3'd6, 7'd3, 1'b1));
    directed.push_back(make_request(CMD_CURSOR, 8'h78, 3'd7, 7'd4, 1'b1));
    directed.push_back(make_request(CMD_INSTR, 8'hA5, 3'd0, 7'd0, 1'b0));
    directed.push_back(make_request(CMD_BUSY, 8'h00, 3'd0, 7'd0, 1'b0));
    foreach (directed[i]) send_request(directed[i]);

    // random segments, each under a new register setting
    for (seg = 0; seg < 5; seg++) begin
      case (seg)
        0: begin
          pulse = 8'd0;
          gap   = 16'd0;
        end
        1: begin
          pulse = 8'hFF;
          gap   = 16'hFFFF;
        end
        default: begin
          pulse = 8'($urandom);
          gap   = 16'($urandom);
        end
      endcase
      reconfigure(pulse, gap);
      steady = (seg == 2);
      repeat (SEG_REQUESTS) send_request(next_random_request());
    end
    steady = 1'b0;

    // drain, then give stray phases time to show up
    in_push <= 1'b0;
    while (board.phase_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/clnw_pkg.sv
hdl/clnw_front.sv
hdl/clnw_fifo.sv
hdl/clnw_back.sv
hdl/char_lcd_nibble_writer.sv
sim/char_lcd_nibble_writer_test.sv
